FILE: hdl/bvp_pkg.sv
package bvp_pkg;

    // Number formats
    localparam int FRAC_BITS = 24;            // pressure fraction bits
    localparam int TIME_BITS = 24;            // time step fraction bits
    localparam int TS_W      = 20;            // time step field
    localparam int P_W       = 29;            // pressure field
    localparam int S_W       = 32;            // stored chamber pressure
    localparam int CMP_W     = S_W + 2;       // compare headroom
    localparam int SUM_W     = 40;            // rate sum
    localparam int PROD_W    = SUM_W + TS_W + 1;
    localparam int Q_W       = 40;            // increment magnitude
    localparam int NEW_W     = Q_W + 1;       // old plus signed increment
    localparam int DIV_BITS  = 8;             // quotient bits per divide-by-3 step

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    typedef logic signed [P_W-1:0]   t_press;
    typedef logic signed [S_W-1:0]   t_state;
    typedef logic signed [CMP_W-1:0] t_cmp;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic [PROD_W-1:0]       t_umag;
    typedef logic [Q_W-1:0]          t_quot;
    typedef logic signed [NEW_W-1:0] t_new;

    // Fixed-point constants, rounded to nearest
    localparam longint ONE_FX   = longint'(1) << FRAC_BITS;
    localparam longint TENTH_FX = (ONE_FX + 5) / 10;
    localparam longint MILLI_FX = (ONE_FX + 500) / 1000;
    localparam longint EPS_FX   = (ONE_FX + 500000) / 1000000;
    localparam longint TEN_FX   = 10 * ONE_FX;

    localparam longint S_HI = (longint'(1) << (S_W - 1)) - 1;
    localparam longint S_LO = -(longint'(1) << (S_W - 1));
    localparam longint P_HI = (longint'(1) << (P_W - 1)) - 1;
    localparam longint P_LO = -(longint'(1) << (P_W - 1));

    // Half of the divisor, added before the shift for round-to-nearest
    localparam t_umag RND_AB = t_umag'(1) << (TIME_BITS - 1);
    localparam t_umag RND_C  = t_umag'(3) << (TIME_BITS - 1);

    // Handle positions with a meaning of their own
    localparam logic [3:0] POS_VENT       = 4'd1;
    localparam logic [3:0] POS_SPRING_MIN = 4'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCONNECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_TAP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_TAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CYL_TAP    = 3'd4;

    typedef struct packed {
        logic [3:0] position;
        logic       disconnect;
        logic       main_tap;
        logic       feed_tap;
        logic       cyl_tap;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{position: 4'd2, disconnect: 1'b1, main_tap: 1'b1,
                                   feed_tap: 1'b1, cyl_tap: 1'b1};

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_DECIDE,
        OP_SUM,
        OP_MUL,
        OP_RND,
        OP_DIV3,
        OP_ACC,
        OP_COMMIT,
        OP_DONE
    } t_op;

    typedef enum logic [1:0] {
        CH_A,
        CH_B,
        CH_C
    } t_chamber;

    // Sequencer to datapath control
    typedef struct packed {
        t_op      op;
        t_chamber ch;
        logic     take_in;
        logic     load_out;
    } t_ctrl;

    // Microprogram
    localparam int UC_DEPTH = 21;
    localparam int UC_AW    = $clog2(UC_DEPTH);
    typedef logic [UC_AW-1:0] t_uaddr;

    typedef struct packed {
        t_op      op;
        t_chamber ch;
        logic     jump;
        t_uaddr   target;
    } t_uword;

    localparam t_uaddr UA_FETCH  = t_uaddr'(0);
    localparam t_uaddr UA_DONE   = t_uaddr'(19);
    localparam t_uaddr UA_COMMIT = t_uaddr'(20);

    // Update: decide, then sum/multiply/round/accumulate per chamber; the
    // control chamber passes through five divide-by-3 steps. Commit: copy, done.
    function automatic t_uword ucode(input t_uaddr pc);
        unique case (pc)
            t_uaddr'(0):  return '{OP_FETCH,  CH_A, 1'b1, UA_COMMIT};
            t_uaddr'(1):  return '{OP_DECIDE, CH_A, 1'b0, UA_FETCH};
            t_uaddr'(2):  return '{OP_SUM,    CH_A, 1'b0, UA_FETCH};
            t_uaddr'(3):  return '{OP_MUL,    CH_A, 1'b0, UA_FETCH};
            t_uaddr'(4):  return '{OP_RND,    CH_A, 1'b0, UA_FETCH};
            t_uaddr'(5):  return '{OP_ACC,    CH_A, 1'b0, UA_FETCH};
            t_uaddr'(6):  return '{OP_SUM,    CH_B, 1'b0, UA_FETCH};
            t_uaddr'(7):  return '{OP_MUL,    CH_B, 1'b0, UA_FETCH};
            t_uaddr'(8):  return '{OP_RND,    CH_B, 1'b0, UA_FETCH};
            t_uaddr'(9):  return '{OP_ACC,    CH_B, 1'b0, UA_FETCH};
            t_uaddr'(10): return '{OP_SUM,    CH_C, 1'b0, UA_FETCH};
            t_uaddr'(11): return '{OP_MUL,    CH_C, 1'b0, UA_FETCH};
            t_uaddr'(12): return '{OP_RND,    CH_C, 1'b0, UA_FETCH};
            t_uaddr'(13): return '{OP_DIV3,   CH_C, 1'b0, UA_FETCH};
            t_uaddr'(14): return '{OP_DIV3,   CH_C, 1'b0, UA_FETCH};
            t_uaddr'(15): return '{OP_DIV3,   CH_C, 1'b0, UA_FETCH};
            t_uaddr'(16): return '{OP_DIV3,   CH_C, 1'b0, UA_FETCH};
            t_uaddr'(17): return '{OP_DIV3,   CH_C, 1'b0, UA_FETCH};
            t_uaddr'(18): return '{OP_ACC,    CH_C, 1'b0, UA_FETCH};
            t_uaddr'(19): return '{OP_DONE,   CH_A, 1'b1, UA_FETCH};
            t_uaddr'(20): return '{OP_COMMIT, CH_A, 1'b1, UA_DONE};
            default:      return '{OP_NOP,    CH_A, 1'b1, UA_FETCH};
        endcase
    endfunction

    // Spring pressure position/25 above the lap position (16-entry table);
    // each entry is worked out from a constant position
    function automatic t_state spring_fx(input logic [3:0] pos);
        t_state val;
        val = '0;
        for (int k = int'(POS_SPRING_MIN) + 1; k < 16; k++) begin
            if (pos == 4'(k))
                val = t_state'((longint'(k) * ONE_FX + 12) / 25);
        end
        return val;
    endfunction

    function automatic t_state sat32(input t_new v);
        if (v > t_new'(S_HI))
            return t_state'(S_HI);
        else if (v < t_new'(S_LO))
            return t_state'(S_LO);
        else
            return t_state'(v);
    endfunction

    function automatic t_press sat29(input t_state v);
        if (v > t_state'(P_HI))
            return t_press'(P_HI);
        else if (v < t_state'(P_LO))
            return t_press'(P_LO);
        else
            return t_press'(v);
    endfunction

endpackage

FILE: hdl/bvp_sequencer.sv
module bvp_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    input  logic           i_out_busy,
    output logic           o_in_ready,
    output bvp_pkg::t_ctrl o_ctrl
);
    import bvp_pkg::*;

    t_uaddr r_pc;
    t_uaddr n_pc;
    t_uword uw;
    logic   take;

    // Control word fetch and next step
    always_comb begin
        uw   = ucode(r_pc);
        take = i_in_valid && (uw.op == OP_FETCH);
        n_pc = r_pc + t_uaddr'(1);
        unique case (uw.op)
            OP_FETCH: begin
                if (!take)
                    n_pc = r_pc;
                else if (i_kind)
                    n_pc = uw.target;
            end
            OP_DONE: begin
                // hold until the result register can take the new result
                n_pc = i_out_busy ? r_pc : uw.target;
            end
            default: begin
                if (uw.jump)
                    n_pc = uw.target;
            end
        endcase
        o_ctrl = '{op: uw.op, ch: uw.ch, take_in: take,
                   load_out: (uw.op == OP_DONE) && !i_out_busy};
    end

    assign o_in_ready = (uw.op == OP_FETCH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_pc <= UA_FETCH;
        else
            r_pc <= n_pc;
    end

endmodule

FILE: hdl/bvp_datapath.sv
module bvp_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  bvp_pkg::t_ctrl            i_ctrl,
    input  bvp_pkg::t_cfg             i_cfg,
    input  logic [bvp_pkg::TS_W-1:0]  i_time_step,
    input  bvp_pkg::t_press           i_main_pressure,
    input  bvp_pkg::t_press           i_cylinder_pressure,
    input  bvp_pkg::t_press           i_feed_pressure,
    output logic                      o_fill_open,
    output logic                      o_vent_open,
    output bvp_pkg::t_press           o_chamber_a_committed,
    output bvp_pkg::t_press           o_chamber_b_committed,
    output logic                      o_pressure_error
);
    import bvp_pkg::*;

    // Chamber state
    t_state r_a_new, r_b_new, r_c_new;
    t_state r_a_old, r_b_old, r_c_old;
    logic   r_fill, r_vent;

    // Request and working registers
    logic [TS_W-1:0] r_ts;
    t_press          r_pm, r_cyl, r_feed;
    logic            r_feed_b;
    logic            r_err;
    t_sum            r_sum;
    t_prod           r_prod;
    t_quot           r_q;
    logic [1:0]      r_rem;
    logic            r_neg;

    // Result register
    logic   r_o_fill, r_o_vent, r_o_err;
    t_press r_o_a, r_o_b;

    // Valve decision
    t_state spring, piston;
    t_cmp   cyl_w, pist_w;
    logic   fill_hit, vent_hit, feed_b;

    always_comb begin
        spring   = spring_fx(i_cfg.position);
        piston   = (spring > r_c_new) ? spring : r_c_new;
        cyl_w    = t_cmp'(r_cyl);
        pist_w   = t_cmp'(piston);
        fill_hit = (cyl_w < pist_w - t_cmp'(MILLI_FX)) && (r_cyl < r_pm);
        vent_hit = cyl_w > pist_w + t_cmp'(MILLI_FX);
        feed_b   = i_cfg.feed_tap &&
                   (t_cmp'(r_b_new) + t_cmp'(TENTH_FX) >= t_cmp'(r_a_new));
    end

    // Rate sums
    t_sum d_fa, d_fb, d_cb, d_bc;
    t_sum sum_a, sum_b, sum_c, sum_sel;

    always_comb begin
        d_fa  = t_sum'(r_feed) - t_sum'(r_a_old);
        d_fb  = t_sum'(r_feed) - t_sum'(r_b_old);
        d_cb  = t_sum'(r_c_old) - t_sum'(r_b_old);
        d_bc  = t_sum'(r_b_old) - t_sum'(r_c_old);
        sum_a = i_cfg.feed_tap ? d_fa * t_sum'(10) : t_sum'(0);
        sum_b = d_cb * t_sum'(5)
              + (r_feed_b ? d_fb * t_sum'(50) : t_sum'(0))
              - ((i_cfg.position == POS_VENT) ? t_sum'(r_b_old) * t_sum'(40) : t_sum'(0));
        sum_c = d_bc * t_sum'(5);
        unique case (i_ctrl.ch)
            CH_A:    sum_sel = sum_a;
            CH_B:    sum_sel = sum_b;
            default: sum_sel = sum_c;
        endcase
    end

    // Shared multiplier: sum times time step
    t_prod prod_w;
    assign prod_w = r_sum * $signed({1'b0, r_ts});

    // Magnitude with rounding, then drop the time fraction
    t_umag rnd_c, mag;

    always_comb begin
        rnd_c = (i_ctrl.ch == CH_C) ? RND_C : RND_AB;
        mag   = (r_prod[PROD_W-1] ? ~t_umag'(r_prod) : t_umag'(r_prod))
              + rnd_c + t_umag'(r_prod[PROD_W-1]);
    end

    // Divide by 3, restoring, a byte of quotient per step
    t_quot      dq;
    logic [1:0] rem;
    logic [2:0] trial;

    always_comb begin
        dq  = r_q;
        rem = r_rem;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {rem, dq[Q_W-1]};
            if (trial >= 3'd3) begin
                rem = 2'(trial - 3'd3);
                dq  = {dq[Q_W-2:0], 1'b1};
            end else begin
                rem = trial[1:0];
                dq  = {dq[Q_W-2:0], 1'b0};
            end
        end
    end

    // Euler step, range check and saturation
    t_state old_sel, acc_sat;
    t_new   acc_v;
    logic   acc_bad;

    always_comb begin
        unique case (i_ctrl.ch)
            CH_A:    old_sel = r_a_old;
            CH_B:    old_sel = r_b_old;
            default: old_sel = r_c_old;
        endcase
        acc_v   = t_new'(old_sel) + (r_neg ? -t_new'(r_q) : t_new'(r_q));
        acc_bad = (acc_v > t_new'(TEN_FX)) || (acc_v < t_new'(-EPS_FX));
        acc_sat = sat32(acc_v);
    end

    // Chamber state and valve openings
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_new <= '0;
            r_b_new <= '0;
            r_c_new <= '0;
            r_a_old <= '0;
            r_b_old <= '0;
            r_c_old <= '0;
            r_fill  <= 1'b0;
            r_vent  <= 1'b0;
        end else begin
            unique case (i_ctrl.op)
                OP_DECIDE: begin
                    r_fill <= fill_hit & i_cfg.main_tap & i_cfg.cyl_tap & i_cfg.disconnect;
                    r_vent <= !fill_hit & vent_hit & i_cfg.cyl_tap & i_cfg.disconnect;
                end
                OP_ACC: begin
                    unique case (i_ctrl.ch)
                        CH_A:    r_a_new <= acc_sat;
                        CH_B:    r_b_new <= acc_sat;
                        default: r_c_new <= acc_sat;
                    endcase
                end
                OP_COMMIT: begin
                    r_a_old <= r_a_new;
                    r_b_old <= r_b_new;
                    r_c_old <= r_c_new;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.take_in) begin
            r_ts   <= i_time_step;
            r_pm   <= i_main_pressure;
            r_cyl  <= i_cylinder_pressure;
            r_feed <= i_feed_pressure;
            r_err  <= 1'b0;
        end
        unique case (i_ctrl.op)
            OP_DECIDE: r_feed_b <= feed_b;
            OP_SUM:    r_sum    <= sum_sel;
            OP_MUL:    r_prod   <= prod_w;
            OP_RND: begin
                r_q   <= t_quot'(mag >> TIME_BITS);
                r_neg <= r_prod[PROD_W-1];
                r_rem <= 2'd0;
            end
            OP_DIV3: begin
                r_q   <= dq;
                r_rem <= rem;
            end
            OP_ACC: begin
                if (acc_bad)
                    r_err <= 1'b1;
            end
            default: ;
        endcase
        if (i_ctrl.load_out) begin
            r_o_fill <= r_fill;
            r_o_vent <= r_vent;
            r_o_a    <= sat29(r_a_old);
            r_o_b    <= sat29(r_b_old);
            r_o_err  <= r_err;
        end
    end

    assign o_fill_open           = r_o_fill;
    assign o_vent_open           = r_o_vent;
    assign o_chamber_a_committed = r_o_a;
    assign o_chamber_b_committed = r_o_b;
    assign o_pressure_error      = r_o_err;

endmodule

FILE: hdl/brake_valve_pneumatic_step.sv
// An update request takes the decide step, three sum/multiply/round/accumulate passes
// through one shared multiplier plus five divide-by-3 steps for the control chamber,
// then the done step; a commit copies the new chamber pressures into the committed ones
// and takes the done step. A new request is taken only after the last one's done step,
// which a result still waiting to be taken holds. Reset (synchronous, active low) clears
// all chamber pressures and the valve openings and loads the register defaults.
module brake_valve_pneumatic_step (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_kind,
    input  logic [bvp_pkg::TS_W-1:0]         i_time_step,
    input  bvp_pkg::t_press                  i_main_pressure,
    input  bvp_pkg::t_press                  i_cylinder_pressure,
    input  bvp_pkg::t_press                  i_feed_pressure,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_fill_open,
    output logic                             o_vent_open,
    output bvp_pkg::t_press                  o_chamber_a_committed,
    output bvp_pkg::t_press                  o_chamber_b_committed,
    output logic                             o_pressure_error,
    input  logic                             i_cfg_we,
    input  logic [bvp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bvp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bvp_pkg::*;

    t_cfg  r_cfg;
    logic  r_out_valid;
    logic  out_busy;
    t_ctrl ctrl;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HANDLE:     r_cfg.position   <= i_cfg_data;
                CFG_DISCONNECT: r_cfg.disconnect <= i_cfg_data[0];
                CFG_MAIN_TAP:   r_cfg.main_tap   <= i_cfg_data[0];
                CFG_FEED_TAP:   r_cfg.feed_tap   <= i_cfg_data[0];
                CFG_CYL_TAP:    r_cfg.cyl_tap    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Result register handshake
    assign out_busy = r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (ctrl.load_out)
            r_out_valid <= 1'b1;
        else if (i_out_ready)
            r_out_valid <= 1'b0;
    end

    assign o_out_valid = r_out_valid;

    bvp_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_out_busy (out_busy),
        .o_in_ready (o_in_ready),
        .o_ctrl     (ctrl)
    );

    bvp_datapath u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_ctrl                (ctrl),
        .i_cfg                 (r_cfg),
        .i_time_step           (i_time_step),
        .i_main_pressure       (i_main_pressure),
        .i_cylinder_pressure   (i_cylinder_pressure),
        .i_feed_pressure       (i_feed_pressure),
        .o_fill_open           (o_fill_open),
        .o_vent_open           (o_vent_open),
        .o_chamber_a_committed (o_chamber_a_committed),
        .o_chamber_b_committed (o_chamber_b_committed),
        .o_pressure_error      (o_pressure_error)
    );

endmodule

FILE: hdl/bvp_checker.sv
module bvp_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready
);

    // A waiting result is not dropped
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // Reset leaves the block empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

    // One request at a time: acceptance closes the input
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while one is in work");

    // Delivering a result returns the sequencer to fetch
    a_result_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("input not reopened with a new result");

endmodule

bind brake_valve_pneumatic_step bvp_checker u_bvp_checker (.*);
